// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the keyframe block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define KCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kce_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe curve evaluator package
// Field widths, codes, the keyframe record and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int KEY_W        = 32;
  localparam int MODE_W       = 3;
  localparam int IDX_OUT_W    = 7;
  localparam int STATUS_W     = 2;
  localparam int DEF_MAX_KEYS = 64;

  // Q16.16 one.
  localparam logic [17:0] ONE_Q16 = 18'd65536;

  // Action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_EVAL   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Interpolation modes; codes six and seven behave like linear.
  localparam logic [MODE_W-1:0] MODE_STEP     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SMOOTH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EASE_IN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EASE_OUT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BEZIER   = 3'd5;

  // One stored keyframe.
  typedef struct packed {
    logic signed [KEY_W-1:0]  beat;
    logic signed [KEY_W-1:0]  value;
    logic [MODE_W-1:0]        mode;
    logic signed [KEY_W-1:0]  tin;
    logic signed [KEY_W-1:0]  tout;
  } key_t;

  // Clamp a 40-bit signed value to the signed 32-bit range.
  function automatic logic signed [KEY_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = -40'sh0080000000;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[KEY_W-1:0];
  endfunction

endpackage

// ===== rtl/kce_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one insert or evaluate item.
// ----------------------------------------------------------------------------
interface kce_in_if import kce_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] beat;
  logic signed [KEY_W-1:0] value;
  logic [MODE_W-1:0]       mode;
  logic signed [KEY_W-1:0] tangent_in;
  logic signed [KEY_W-1:0] tangent_out;

  modport source (output valid, action, beat, value, mode, tangent_in, tangent_out,
                  input ready);
  modport sink   (input valid, action, beat, value, mode, tangent_in, tangent_out,
                  output ready);
endinterface

// ===== rtl/kce_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface kce_out_if import kce_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] result_value;
  logic [IDX_OUT_W-1:0]    insert_index;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, result_value, insert_index, status, input ready);
  modport sink   (input valid, result_value, insert_index, status, output ready);
endinterface

// ===== rtl/kce_cell.sv =====
// ----------------------------------------------------------------------------
// Keyframe cell
// Holds one keyframe of the sorted row and shifts right on an insert.
// ----------------------------------------------------------------------------
module kce_cell import kce_pkg::*; (
  input  logic                    clk,
  input  logic                    valid,
  input  logic signed [KEY_W-1:0] q_beat,
  input  logic                    ins_en,
  input  key_t                    ins_key,
  input  key_t                    left_key,
  input  logic                    left_lt,
  output key_t                    key,
  output logic                    lt,
  output logic                    hit
);

  // A valid cell below the query stays put; the first cell at or above it
  // marks the lower-bound position.
  always_comb begin
    lt  = valid && (key.beat < q_beat);
    hit = !lt && left_lt;
  end

  // On insert the boundary cell takes the new keyframe, cells right of it
  // take their left neighbor.
  always_ff @(posedge clk) begin
    if (ins_en && !lt) begin
      key <= left_lt ? ins_key : left_key;
    end
  end

endmodule

// ===== rtl/kce_arith.sv =====
// ----------------------------------------------------------------------------
// Segment interpolator
// Serial divider for t followed by a one-multiplier step sequencer.
// ----------------------------------------------------------------------------
module kce_arith import kce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [KEY_W-1:0] q_beat,
  input  key_t                    pkey,
  input  key_t                    nkey,
  output logic                    done,
  output logic signed [KEY_W-1:0] result
);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_DIV  = 3'b010,
    A_POLY = 3'b100
  } astate_t;

  astate_t                 state;
  logic [4:0]              step;
  logic [KEY_W-1:0]        dt;
  logic [KEY_W+1:0]        rem;
  logic [16:0]             t;
  logic [17:0]             t2, t3, u, u2, u3, w1, w2, e;
  logic signed [KEY_W-1:0] pv, nv, ptout, ntin;
  logic [MODE_W-1:0]       mode;
  logic signed [55:0]      acc;

  logic signed [33:0]      ma;
  logic signed [19:0]      mb;
  logic signed [53:0]      prod;
  logic signed [32:0]      beat_diff, query_diff;
  logic signed [20:0]      smooth_e;
  logic [17:0]             e_sel;
  logic signed [39:0]      mix_sum;
  logic                    is_bez;

  assign is_bez     = (mode == MODE_BEZIER);
  assign beat_diff  = 33'(nkey.beat) - 33'(pkey.beat);
  assign query_diff = 33'(q_beat) - 33'(pkey.beat);

  // Easing weight for the non-Bezier modes.
  always_comb begin
    smooth_e = 21'sd3 * $signed({3'b0, t2}) - 21'sd2 * $signed({3'b0, t3});
    unique case (mode)
      MODE_SMOOTH: begin
        if (smooth_e < 21'sd0) begin
          e_sel = '0;
        end else if (smooth_e > $signed({3'b0, ONE_Q16})) begin
          e_sel = ONE_Q16;
        end else begin
          e_sel = smooth_e[17:0];
        end
      end
      MODE_EASE_IN:  e_sel = t2;
      MODE_EASE_OUT: e_sel = ONE_Q16 - u2;
      default:       e_sel = {1'b0, t};
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step)
      5'd0: begin ma = 34'({t});           mb = 20'({t});  end
      5'd1: begin ma = 34'({t2});          mb = 20'({t});  end
      5'd2: begin ma = 34'({u});           mb = 20'(u);    end
      5'd3: begin ma = 34'({u2});          mb = 20'(u);    end
      5'd4: begin ma = 34'(20'd3 * u2);    mb = 20'({t});  end
      5'd5: begin ma = 34'(20'd3 * u);     mb = 20'(t2);   end
      5'd6: begin ma = 34'(pv);            mb = 20'(u3);   end
      5'd7: begin
        if (is_bez) begin
          ma = 34'(pv) + 34'(ptout);
          mb = 20'(w1);
        end else begin
          ma = 34'(nv) - 34'(pv);
          mb = 20'(e);
        end
      end
      5'd8: begin ma = 34'(nv) + 34'(ntin); mb = 20'(w2); end
      5'd9: begin ma = 34'(nv);             mb = 20'(t3); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  assign mix_sum = 40'(pv) + 40'($signed(prod[53:16]));

  // Divider iterations, then the product steps.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= A_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            dt    <= beat_diff[KEY_W-1:0];
            rem   <= {2'b0, query_diff[KEY_W-1:0]};
            t     <= '0;
            pv    <= pkey.value;
            nv    <= nkey.value;
            ptout <= pkey.tout;
            ntin  <= nkey.tin;
            mode  <= pkey.mode;
            step  <= '0;
            state <= A_DIV;
          end
        end
        A_DIV: begin
          if (rem >= {2'b0, dt}) begin
            t   <= {t[15:0], 1'b1};
            rem <= (rem - {2'b0, dt}) << 1;
          end else begin
            t   <= {t[15:0], 1'b0};
            rem <= rem << 1;
          end
          if (step == 5'd16) begin
            step  <= '0;
            state <= A_POLY;
          end else begin
            step <= step + 5'd1;
          end
        end
        A_POLY: begin
          step <= step + 5'd1;
          unique case (step)
            5'd0: begin t2 <= prod[33:16]; u <= ONE_Q16 - {1'b0, t}; end
            5'd1: t3 <= prod[33:16];
            5'd2: u2 <= prod[33:16];
            5'd3: u3 <= prod[33:16];
            5'd4: w1 <= prod[33:16];
            5'd5: w2 <= prod[33:16];
            5'd6: begin
              e   <= e_sel;
              acc <= 56'(prod);
            end
            5'd7: begin
              if (is_bez) begin
                acc <= acc + 56'(prod);
              end else begin
                result <= sat32(mix_sum);
                done   <= 1'b1;
                state  <= A_IDLE;
              end
            end
            5'd8: acc <= acc + 56'(prod);
            5'd9: acc <= acc + 56'(prod);
            default: begin
              result <= sat32(acc[55:16]);
              done   <= 1'b1;
              state  <= A_IDLE;
            end
          endcase
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/keyframe_curve_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// Keyframe curve evaluator
// Sorted keyframe row with insert and curve evaluation.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_KEYS keyframes in a row of cells sorted by beat
// and handles one item at a time. An insert is captured, then every cell
// compares against the beat and the row shifts right behind the insert point,
// then the result is presented once the output register is free. An evaluate
// that clamps to an end or hits a step segment, an evaluate on an empty table
// and an insert into a full table take the same path. An evaluate inside a
// segment goes on to the arithmetic: a serial divider forms the 17 bits of t,
// then a single shared multiplier runs the powers of t and the blend in 8 to
// 11 steps. The next item is accepted once the current result is handed to
// the output register.
module keyframe_curve_evaluator_top import kce_pkg::*; #(
  parameter int MAX_KEYS = DEF_MAX_KEYS
) (
  input  logic      clk,
  input  logic      rst,
  kce_in_if.sink    in_ch,
  kce_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_CALC   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic                    act;
  logic signed [KEY_W-1:0] q_beat;
  key_t                    ins_key;
  logic signed [KEY_W-1:0] res_val;
  logic [IDX_OUT_W-1:0]    res_idx;
  logic [STATUS_W-1:0]     res_st;

  key_t                    keys [MAX_KEYS];
  logic [MAX_KEYS-1:0]     lt;
  logic [MAX_KEYS-1:0]     hit;
  key_t                    sel_next, sel_prev, sel_last;
  logic [CNT_W-1:0]        hit_idx;
  logic [CNT_W-1:0]        last_pos;
  logic                    full;
  logic                    ins_en;
  logic                    calc_start;
  logic                    calc_done;
  logic signed [KEY_W-1:0] calc_res;

  assign full     = (cnt == CNT_W'(MAX_KEYS));
  assign last_pos = cnt - CNT_W'(1);
  assign ins_en   = (state == S_SEARCH) && (act == ACT_INSERT) && !full;

  // Row of keyframe cells.
  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    kce_cell u_cell (
      .clk      (clk),
      .valid    (CNT_W'(i) < cnt),
      .q_beat   (q_beat),
      .ins_en   (ins_en),
      .ins_key  (ins_key),
      .left_key ((i == 0) ? ins_key : keys[(i == 0) ? 0 : i - 1]),
      .left_lt  ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
      .key      (keys[i]),
      .lt       (lt[i]),
      .hit      (hit[i])
    );
  end

  // Pick the segment ends, the last keyframe and the insert position.
  always_comb begin
    sel_next = '0;
    sel_prev = '0;
    sel_last = '0;
    hit_idx  = '0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (hit[i]) begin
        sel_next = sel_next | keys[i];
        hit_idx  = hit_idx | CNT_W'(i);
      end
      if (CNT_W'(i) == last_pos) begin
        sel_last = sel_last | keys[i];
      end
    end
    for (int i = 0; i < MAX_KEYS - 1; i++) begin
      if (hit[i + 1]) begin
        sel_prev = sel_prev | keys[i];
      end
    end
  end

  assign calc_start = (state == S_SEARCH) && (act == ACT_EVAL) && (cnt != '0) &&
                      (q_beat > keys[0].beat) && (q_beat < sel_last.beat) &&
                      (sel_prev.mode != MODE_STEP);

  kce_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .start  (calc_start),
    .q_beat (q_beat),
    .pkey   (sel_prev),
    .nkey   (sel_next),
    .done   (calc_done),
    .result (calc_res)
  );

  assign in_ch.ready = (state == S_IDLE);

  // Item sequencing and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // The result register empties on a handshake unless a new item loads it.
      if (out_ch.valid && out_ch.ready && (state != S_DONE)) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            act          <= in_ch.action;
            q_beat       <= in_ch.beat;
            ins_key.beat <= in_ch.beat;
            ins_key.value <= in_ch.value;
            ins_key.mode <= in_ch.mode;
            ins_key.tin  <= in_ch.tangent_in;
            ins_key.tout <= in_ch.tangent_out;
            state        <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          res_val <= '0;
          res_idx <= '0;
          res_st  <= ST_OK;
          state   <= S_DONE;
          if (act == ACT_INSERT) begin
            if (full) begin
              res_st <= ST_FULL;
            end else begin
              res_idx <= IDX_OUT_W'(hit_idx);
              cnt     <= cnt + CNT_W'(1);
            end
          end else begin
            priority if (cnt == '0) begin
              res_st <= ST_EMPTY;
            end else if (q_beat <= keys[0].beat) begin
              res_val <= keys[0].value;
            end else if (q_beat >= sel_last.beat) begin
              res_val <= sel_last.value;
            end else if (sel_prev.mode == MODE_STEP) begin
              res_val <= sel_prev.value;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (calc_done) begin
            res_val <= calc_res;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid        <= 1'b1;
            out_ch.result_value <= res_val;
            out_ch.insert_index <= res_idx;
            out_ch.status       <= res_st;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/kce_checker.sv =====
// ----------------------------------------------------------------------------
// Keyframe evaluator port checker
// Port-level assertions on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kce_checker import kce_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic signed [KEY_W-1:0] out_value,
  input logic [IDX_OUT_W-1:0]    out_index,
  input logic [STATUS_W-1:0]     out_status
);

  // Only defined status codes leave the block.
  `KCE_ASSERT(a_status_code, !out_valid || out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY, "undefined status code")

  // A dropped insert reports neither position nor value.
  `KCE_ASSERT(a_full_clean, !(out_valid && out_status == ST_FULL) || (out_index == '0 && out_value == '0), "full result carries data")

  // An evaluate on an empty table yields zero.
  `KCE_ASSERT(a_empty_clean, !(out_valid && out_status == ST_EMPTY) || (out_index == '0 && out_value == '0), "empty result carries data")

  // One item at a time: no second item right behind an accepted one.
  `KCE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input ready right after an accepted item")

endmodule

bind keyframe_curve_evaluator_top kce_checker u_kce_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_value  (out_ch.result_value),
  .out_index  (out_ch.insert_index),
  .out_status (out_ch.status)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Keyframe curve evaluator testbench
// Drives insert and evaluate items into the block. A local curve model
// predicts every result, and each result item is checked field by field
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb import kce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS = DEF_MAX_KEYS;

  typedef struct {
    logic                    action;
    logic signed [KEY_W-1:0] beat;
    logic signed [KEY_W-1:0] value;
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] tin;
    logic signed [KEY_W-1:0] tout;
  } kf_item_t;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    logic [IDX_OUT_W-1:0]    index;
    logic [STATUS_W-1:0]     status;
  } curve_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kce_in_if  in_ch();
  kce_out_if out_ch();

  keyframe_curve_evaluator_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the keyframe table.
  logic signed [KEY_W-1:0] shadow_beat[NKEYS];
  logic signed [KEY_W-1:0] shadow_value[NKEYS];
  logic [MODE_W-1:0]       shadow_mode[NKEYS];
  logic signed [KEY_W-1:0] shadow_tin[NKEYS];
  logic signed [KEY_W-1:0] shadow_tout[NKEYS];
  int                      shadow_count = 0;

  curve_res_t pending_results[$];
  int  mismatches = 0;
  int  checked = 0;
  int  n_inserts = 0;
  int  n_evals = 0;
  bit  quiet = 1'b0;
  bit  holding = 1'b0;
  event hold_go;

  // First table position whose beat is not below b.
  function automatic int lower_slot(logic signed [KEY_W-1:0] b);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_beat[mid] < b) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic longint blend(longint a, longint b, longint e);
    return a + (((b - a) * e) >>> 16);
  endfunction

  // Interpolate inside the segment p..p+1.
  function automatic longint segment_value(int p, logic signed [KEY_W-1:0] b);
    longint pv, nv, dt, t, t2, t3, u, u2, u3, e, p1, p2, w1, w2;
    pv = shadow_value[p];
    nv = shadow_value[p+1];
    dt = longint'(shadow_beat[p+1]) - longint'(shadow_beat[p]);
    if (dt <= 0) return pv;
    t = ((longint'(b) - longint'(shadow_beat[p])) * 65536) / dt;
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    u  = 65536 - t;
    u2 = (u * u) >>> 16;
    u3 = (u2 * u) >>> 16;
    case (shadow_mode[p])
      MODE_STEP: return pv;
      MODE_SMOOTH: begin
        e = 3 * t2 - 2 * t3;
        if (e < 0) e = 0;
        if (e > 65536) e = 65536;
        return blend(pv, nv, e);
      end
      MODE_EASE_IN:  return blend(pv, nv, t2);
      MODE_EASE_OUT: return blend(pv, nv, 65536 - u2);
      MODE_BEZIER: begin
        p1 = pv + longint'(shadow_tout[p]);
        p2 = nv + longint'(shadow_tin[p+1]);
        w1 = (3 * u2 * t) >>> 16;
        w2 = (3 * u * t2) >>> 16;
        return (u3 * pv + w1 * p1 + w2 * p2 + t3 * nv) >>> 16;
      end
      default: return blend(pv, nv, t);
    endcase
  endfunction

  // Apply one item to the shadow table and return the result it must give.
  function automatic curve_res_t apply_item(kf_item_t it);
    curve_res_t r;
    longint v;
    int idx;
    r.value = '0;
    r.index = '0;
    r.status = ST_OK;
    v = 0;
    if (it.action == ACT_INSERT) begin
      if (shadow_count >= NKEYS) begin
        r.status = ST_FULL;
      end else begin
        idx = lower_slot(it.beat);
        for (int i = shadow_count; i > idx; i--) begin
          shadow_beat[i]  = shadow_beat[i-1];
          shadow_value[i] = shadow_value[i-1];
          shadow_mode[i]  = shadow_mode[i-1];
          shadow_tin[i]   = shadow_tin[i-1];
          shadow_tout[i]  = shadow_tout[i-1];
        end
        shadow_beat[idx]  = it.beat;
        shadow_value[idx] = it.value;
        shadow_mode[idx]  = it.mode;
        shadow_tin[idx]   = it.tin;
        shadow_tout[idx]  = it.tout;
        shadow_count++;
        r.index = idx[IDX_OUT_W-1:0];
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else if (it.beat <= shadow_beat[0]) begin
        v = shadow_value[0];
      end else if (it.beat >= shadow_beat[shadow_count-1]) begin
        v = shadow_value[shadow_count-1];
      end else begin
        idx = lower_slot(it.beat);
        if (idx == 0) v = shadow_value[0];
        else if (idx >= shadow_count) v = shadow_value[shadow_count-1];
        else v = segment_value(idx - 1, it.beat);
      end
      if (v > 64'sd2147483647) r.value = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r.value = 32'sh80000000;
      else r.value = v[31:0];
    end
    return r;
  endfunction

  // Offer one item, hold it until accepted, then record its prediction.
  task automatic send_item(kf_item_t it);
    curve_res_t exp_res;
    if (!quiet && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= it.action;
    in_ch.beat        <= it.beat;
    in_ch.value       <= it.value;
    in_ch.mode        <= it.mode;
    in_ch.tangent_in  <= it.tin;
    in_ch.tangent_out <= it.tout;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_res = apply_item(it);
    pending_results = {pending_results, exp_res};
    if (it.action == ACT_INSERT) n_inserts++;
    else n_evals++;
  endtask

  task automatic send_insert(logic signed [31:0] b, logic signed [31:0] v,
                             logic [2:0] m, logic signed [31:0] ti, logic signed [31:0] to);
    kf_item_t it;
    it.action = ACT_INSERT;
    it.beat = b;
    it.value = v;
    it.mode = m;
    it.tin = ti;
    it.tout = to;
    send_item(it);
  endtask

  // Evaluates carry random junk in the insert-only fields.
  task automatic send_eval(logic signed [31:0] b);
    kf_item_t it;
    it.action = ACT_EVAL;
    it.beat = b;
    it.value = $urandom;
    it.mode = $urandom_range(7);
    it.tin = $urandom;
    it.tout = $urandom;
    send_item(it);
  endtask

  // Query beat mostly inside a stored segment, sometimes anywhere.
  function automatic logic signed [31:0] pick_query();
    int i;
    longint lo, hi;
    if (shadow_count < 2 || $urandom_range(9) == 0) return $urandom;
    i = $urandom_range(shadow_count - 2);
    lo = shadow_beat[i];
    hi = shadow_beat[i+1];
    case ($urandom_range(5))
      0: return lo[31:0];
      1: return hi[31:0];
      default: return 32'(lo + (longint'($urandom) * (hi - lo)) / 64'sd4294967296);
    endcase
  endfunction

  // Random keyframe beat: wide spread, clustered values, a repeat, or a multiple of 16.
  function automatic logic signed [31:0] pick_key_beat();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return (shadow_count > 0) ? shadow_beat[$urandom_range(shadow_count - 1)]
                                   : $urandom;
      default: return $signed($urandom_range(32'h0010_0000)) <<< 4;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Long receiver stall, counted here once a test asks for it.
  initial begin
    @(hold_go);
    holding <= 1'b1;
    repeat (400) @(posedge clk);
    holding <= 1'b0;
  end

  // Result sink: random back-pressure, a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (holding) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    curve_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (out_ch.result_value !== want.value || out_ch.insert_index !== want.index ||
            out_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: value %0d/%0d index %0d/%0d status %0d/%0d (exp/act)",
                     $realtime, want.value, out_ch.result_value, want.index,
                     out_ch.insert_index, want.status, out_ch.status);
        end
      end
    end
  end

  // Empty table evaluates.
  task automatic test_empty();
    send_eval(32'sh80000000);
    send_eval(32'sh7FFFFFFF);
    send_eval(32'sd0);
  endtask

  // Hand-picked keyframes covering every mode and the beat extremes.
  task automatic test_directed();
    send_insert(32'sh0001_0000, 32'sh0000_0000, MODE_LINEAR, 0, 0);
    send_insert(32'sh0003_0000, 32'sh0004_0000, MODE_SMOOTH, 0, 0);
    send_insert(32'sh0001_0000, 32'sh0002_0000, MODE_STEP, 0, 0);  // equal beat goes first
    send_insert(32'sh0005_0000, 32'sh7FFF_FFFF, MODE_EASE_IN, 0, 0);
    send_insert(32'sh0007_0000, 32'sh8000_0000, MODE_EASE_OUT, 0, 0);
    send_insert(32'sh0009_0000, 32'sh7FFF_FFFF, MODE_BEZIER, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_insert(32'sh000B_0000, 32'sh7FFF_FFFF, 3'd6, 32'sh8000_0000, 32'sh8000_0000);
    send_insert(32'sh000D_0000, 32'sh8000_0000, 3'd7, 0, 0);
    send_insert(32'sh8000_0000, 32'sh1234_5678, MODE_LINEAR, 0, 0);
    send_insert(32'sh7FFF_FFFF, 32'shFFFF_0000, MODE_LINEAR, 0, 0);
    send_eval(32'sh8000_0000);
    send_eval(32'sh7FFF_FFFF);
    send_eval(32'sh0001_0000);
    send_eval(32'sh0001_8000);
    send_eval(32'sh0003_4000);
    send_eval(32'sh0005_C000);
    send_eval(32'sh0007_8000);
    send_eval(32'sh0009_8000);
    send_eval(32'sh000B_8000);
    send_eval(32'sh000D_0001);
    send_eval(32'sh4000_0000);
  endtask

  // Stall the sink for a long stretch while items keep coming.
  task automatic test_backpressure();
    -> hold_go;
    for (int i = 0; i < 20; i++) send_eval(pick_query());
  endtask

  // Random mix; inserts are likelier while the table has room, so it fills up.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= 300 && i < 450);
      if ($urandom_range(99) < ((shadow_count < NKEYS) ? 30 : 4))
        send_insert(pick_key_beat(), $urandom, $urandom_range(7), $urandom, $urandom);
      else
        send_eval(pick_query());
    end
    quiet = 1'b0;
  endtask

  // Inserts into a full table are dropped.
  task automatic test_full();
    while (shadow_count < NKEYS)
      send_insert(pick_key_beat(), $urandom, $urandom_range(7), $urandom, $urandom);
    send_insert(32'sh8000_0000, $urandom, MODE_STEP, $urandom, $urandom);
    send_insert(32'sh7FFF_FFFF, $urandom, MODE_BEZIER, $urandom, $urandom);
    for (int i = 0; i < 10; i++) send_eval(pick_query());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.beat = '0;
    in_ch.value = '0;
    in_ch.mode = '0;
    in_ch.tangent_in = '0;
    in_ch.tangent_out = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty();
    test_directed();
    test_backpressure();
    test_random(1150);
    test_full();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();
    $display("Checked %0d results from %0d inserts and %0d evaluates,", checked,
             n_inserts, n_evals);
    $display("covering all modes, clamps, empty and full table, and a long output stall.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/kce_pkg.sv
rtl/kce_in_if.sv
rtl/kce_out_if.sv
rtl/kce_cell.sv
rtl/kce_arith.sv
rtl/keyframe_curve_evaluator_top.sv
rtl/kce_checker.sv
tb/tb.sv
